// ===== hdl/hgp_pkg.sv =====
// Shared types and constants of the HSV gradient pixel generator.
package hgp_pkg;

  localparam int CW = 21;   // color component, Q.12
  localparam int PW = 29;   // gradient position, Q.20
  localparam int SW = 30;   // signed gradient step, Q.20
  localparam int DNW = 29;  // divider dividend / quotient width
  localparam int RW = 31;   // reciprocal width

  localparam logic [CW-1:0] HUE_SCALE = CW'(360);
  localparam logic [CW-1:0] PCT_SCALE = CW'(100);
  localparam logic [CW-1:0] ONE20 = CW'(1 << 20);
  localparam logic [PW-1:0] SIXTY = PW'(60 << 20);
  localparam logic [PW-1:0] HUE_FULL = PW'(360 << 20);
  localparam logic signed [22:0] HALF_HUE_Q12 = 23'sd737280;   // 180 deg
  localparam logic signed [22:0] FULL_HUE_Q12 = 23'sd1474560;  // 360 deg
  localparam logic [6:0] THR_RESET = 7'd5;

  // reciprocals ceil(2^sh / d), sh = DNW + clog2(d)
  localparam int PCT_SH = DNW + 7;
  localparam int SIXTY_SH = DNW + 6;
  localparam logic [RW-1:0] PCT_RCP =
    RW'(((longint'(1) << PCT_SH) + longint'(99)) / longint'(100));
  localparam logic [RW-1:0] SIXTY_RCP =
    RW'(((longint'(1) << SIXTY_SH) + longint'(59)) / longint'(60));

  typedef enum logic {
    CMD_SAMPLE,
    CMD_PIXEL
  } cmd_kind_e;

  typedef enum logic [1:0] {
    DIV_BY_STEPS,
    DIV_BY_PCT,
    DIV_BY_SIXTY
  } div_sel_e;

  typedef struct packed {
    cmd_kind_e     kind;
    logic [CW-1:0] hue;
    logic [CW-1:0] sat;
    logic [CW-1:0] val;
    logic          sel;
  } cmd_t;

  typedef struct packed {
    logic           start;
    logic [DNW-1:0] dividend;
    div_sel_e       sel;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [DNW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP,
    ST_STEP,
    ST_STEPW,
    ST_PIX,
    ST_PDIV,
    ST_PDIVW,
    ST_MUL,
    ST_MULW,
    ST_OUT
  } back_state_e;

endpackage

// ===== hdl/hgp_if.sv =====
// Channel interfaces: input item channel and pixel result channel.
interface hgp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [11:0] hue_raw;
  logic [11:0] sat_raw;
  logic [11:0] val_raw;
  logic        select_second;
  modport source (output valid, func, hue_raw, sat_raw, val_raw, select_second,
                  input ready);
  modport sink (input valid, func, hue_raw, sat_raw, val_raw, select_second,
                output ready);
endinterface

interface hgp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] grb_word;
  logic [7:0]  pixel_index;
  logic        last_pixel;
  modport source (output valid, grb_word, pixel_index, last_pixel, input ready);
  modport sink (input valid, grb_word, pixel_index, last_pixel, output ready);
endinterface

// ===== hdl/hgp_front.sv =====
// Front end: accepts input items, decodes the kind and scales the readings.
module hgp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  hgp_in_if.sink        in_i,
  output hgp_pkg::cmd_t cmd_o,
  output logic          cmd_vld_o,
  input  logic          cmd_rdy_i
);
  import hgp_pkg::*;

  logic vld_q;
  cmd_t cmd_q, cmd_d;

  assign in_i.ready = !vld_q || cmd_rdy_i;
  assign cmd_o = cmd_q;
  assign cmd_vld_o = vld_q;

  always_comb begin
    cmd_d.kind = in_i.func ? CMD_PIXEL : CMD_SAMPLE;
    cmd_d.hue = CW'(in_i.hue_raw) * HUE_SCALE;
    cmd_d.sat = CW'(in_i.sat_raw) * PCT_SCALE;
    cmd_d.val = CW'(in_i.val_raw) * PCT_SCALE;
    cmd_d.sel = in_i.select_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      vld_q <= 1'b1;
    end else if (cmd_rdy_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== hdl/hgp_queue.sv =====
// Two-entry command queue between front and back.
module hgp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hgp_pkg::cmd_t cmd_i,
  input  logic          vld_i,
  output logic          rdy_o,
  output hgp_pkg::cmd_t cmd_o,
  output logic          vld_o,
  input  logic          rdy_i
);
  import hgp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign rdy_o = (cnt_q != 2'd2);
  assign vld_o = (cnt_q != 2'd0);
  assign cmd_o = mem_q[rd_q];
  assign push = vld_i && rdy_o;
  assign pop = vld_o && rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== hdl/hgp_div.sv =====
// Constant-divisor unit: reciprocal multiply, operands then product registered.
module hgp_div #(
  parameter int PIXEL_COUNT = 150
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hgp_pkg::div_req_t req_i,
  output hgp_pkg::div_rsp_t rsp_o
);
  import hgp_pkg::*;

  // floor(x / d) = (x * ceil(2^sh / d)) >> sh, exact for x < 2^DNW when 2^(sh - DNW) >= d
  localparam int STEP_SH = DNW + $clog2(PIXEL_COUNT - 1);
  localparam logic [RW-1:0] STEP_RCP =
    RW'(((longint'(1) << STEP_SH) + longint'(PIXEL_COUNT - 2)) / longint'(PIXEL_COUNT - 1));

  logic              busy_q, done_q;
  div_sel_e          sel_q;
  logic [DNW-1:0]    num_q;
  logic [RW-1:0]     rcp_q;
  logic [DNW+RW-1:0] prod_q;
  logic [RW-1:0]     rcp;
  logic [DNW-1:0]    quot;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot;

  always_comb begin
    unique case (req_i.sel)
      DIV_BY_STEPS: rcp = STEP_RCP;
      DIV_BY_PCT: rcp = PCT_RCP;
      default: rcp = SIXTY_RCP;
    endcase
  end

  always_comb begin
    unique case (sel_q)
      DIV_BY_STEPS: quot = DNW'(prod_q >> STEP_SH);
      DIV_BY_PCT: quot = DNW'(prod_q >> PCT_SH);
      default: quot = DNW'(prod_q >> SIXTY_SH);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      rcp_q <= rcp;
      sel_q <= req_i.sel;
    end
    if (busy_q) prod_q <= num_q * rcp_q;
  end

endmodule

// ===== hdl/hgp_back.sv =====
// Back end: sample smoothing, step computation and pixel HSV-to-RGB conversion.
module hgp_back #(
  parameter int PIXEL_COUNT = 150
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  hgp_pkg::cmd_t cmd_i,
  input  logic          cmd_vld_i,
  output logic          cmd_rdy_o,
  hgp_out_if.source     pixel_o
);
  import hgp_pkg::*;

  localparam logic [7:0] LAST_IDX = 8'(PIXEL_COUNT - 1);
  localparam logic signed [30:0] HUE_FULL_S = $signed({2'b00, HUE_FULL});

  back_state_e state_q, state_d;
  cmd_t          cmd_q;
  logic [2:0]    k_q;
  logic [6:0]    thr_q;
  logic [CW-1:0] sm_q [3];
  logic [CW-1:0] ca_q [3];
  logic [CW-1:0] e1_q [3];
  logic [CW-1:0] e2_q [3];
  logic [PW-1:0] pos_q [3];
  logic signed [SW-1:0] step_q [3];
  logic [7:0]    cnt_q;
  logic          neg_q;
  logic [2:0]    sector_q;
  logic [PW-1:0] rem_q;
  logic [CW-1:0] vf_q, sf_q, f_q, p_q, q_q, t_q, fs_q, fs2_q;
  logic [2*CW-1:0] prod_q;
  logic          out_vld_q;
  logic [23:0]   grb_q;
  logic [7:0]    idx_q;
  logic          last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  hgp_div #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic out_free;
  assign out_free = !out_vld_q || pixel_o.ready;
  assign pixel_o.valid = out_vld_q;
  assign pixel_o.grb_word = grb_q;
  assign pixel_o.pixel_index = idx_q;
  assign pixel_o.last_pixel = last_q;

  // sample smoothing and change test
  logic [CW-1:0] fresh [3];
  logic [CW-1:0] sm_new [3];
  logic          changed;
  always_comb begin
    logic signed [22:0] df;
    fresh[0] = cmd_q.hue;
    fresh[1] = cmd_q.sat;
    fresh[2] = cmd_q.val;
    changed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sm_new[i] = CW'(({1'b0, sm_q[i]} + {1'b0, fresh[i]}) >> 1);
      df = $signed({2'b00, sm_new[i]}) - $signed({2'b00, ca_q[i]});
      if (df < 0) df = -df;
      if (df > $signed({4'b0, thr_q, 12'b0})) changed = 1'b1;
    end
  end

  // endpoint difference for the current component, hue on the short arc
  logic signed [22:0] d_ep;
  logic [CW-1:0]      d_mag;
  always_comb begin
    d_ep = $signed({2'b00, e2_q[k_q[1:0]]}) - $signed({2'b00, e1_q[k_q[1:0]]});
    if (k_q == 3'd0) begin
      if (d_ep > HALF_HUE_Q12) d_ep = d_ep - FULL_HUE_Q12;
      else if (d_ep < -HALF_HUE_Q12) d_ep = d_ep + FULL_HUE_Q12;
    end
    d_mag = d_ep < 0 ? CW'(-d_ep) : CW'(d_ep);
  end

  // hue sector
  logic [2:0]    sector;
  logic [PW-1:0] sec_base;
  always_comb begin
    priority if (pos_q[0] >= PW'(5 * (60 << 20))) sector = 3'd5;
    else if (pos_q[0] >= PW'(4 * (60 << 20))) sector = 3'd4;
    else if (pos_q[0] >= PW'(3 * (60 << 20))) sector = 3'd3;
    else if (pos_q[0] >= PW'(2 * (60 << 20))) sector = 3'd2;
    else if (pos_q[0] >= SIXTY) sector = 3'd1;
    else sector = 3'd0;
    sec_base = PW'(sector * SIXTY);
  end

  // shared multiplier operands
  logic [CW-1:0] mul_a, mul_b;
  always_comb begin
    unique case (k_q)
      3'd0: begin mul_a = vf_q; mul_b = ONE20 - sf_q; end
      3'd1: begin mul_a = f_q; mul_b = sf_q; end
      3'd2: begin mul_a = ONE20 - f_q; mul_b = sf_q; end
      3'd3: begin mul_a = vf_q; mul_b = ONE20 - fs_q; end
      default: begin mul_a = vf_q; mul_b = ONE20 - fs2_q; end
    endcase
  end

  // sector table and byte conversion
  function automatic logic [7:0] to_byte(logic [CW-1:0] x);
    logic [PW-1:0] c;
    c = (({8'b0, x} << 8) - {8'b0, x}) >> 20;
    return (c > PW'(255)) ? 8'hFF : c[7:0];
  endfunction

  logic [CW-1:0] r_x, g_x, b_x;
  always_comb begin
    unique case (sector_q)
      3'd0: begin r_x = vf_q; g_x = t_q; b_x = p_q; end
      3'd1: begin r_x = q_q; g_x = vf_q; b_x = p_q; end
      3'd2: begin r_x = p_q; g_x = vf_q; b_x = t_q; end
      3'd3: begin r_x = p_q; g_x = q_q; b_x = vf_q; end
      3'd4: begin r_x = t_q; g_x = p_q; b_x = vf_q; end
      default: begin r_x = vf_q; g_x = p_q; b_x = q_q; end
    endcase
  end

  // hue advance with wrap
  logic signed [30:0] h_sum;
  logic [PW-1:0]      h_next;
  always_comb begin
    h_sum = $signed({2'b00, pos_q[0]}) + 31'(step_q[0]);
    if (h_sum >= HUE_FULL_S) h_sum = h_sum - HUE_FULL_S;
    else if (h_sum < 0) h_sum = h_sum + HUE_FULL_S;
    h_next = h_sum[PW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_vld_i) state_d = (cmd_i.kind == CMD_SAMPLE) ? ST_SMP : ST_PIX;
      ST_SMP: state_d = ST_STEP;
      ST_STEP: state_d = ST_STEPW;
      ST_STEPW: if (div_rsp.done) state_d = (k_q == 3'd2) ? ST_IDLE : ST_STEP;
      ST_PIX: state_d = ST_PDIV;
      ST_PDIV: state_d = ST_PDIVW;
      ST_PDIVW: if (div_rsp.done) state_d = (k_q == 3'd2) ? ST_MUL : ST_PDIV;
      ST_MUL: state_d = ST_MULW;
      ST_MULW: state_d = (k_q == 3'd4) ? ST_OUT : ST_MUL;
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_rdy_o = (state_q == ST_IDLE);
    div_req.start = (state_q == ST_STEP) || (state_q == ST_PDIV);
    div_req.dividend = {d_mag, 8'b0};
    div_req.sel = DIV_BY_STEPS;
    if (state_q == ST_PDIV) begin
      unique case (k_q)
        3'd0: begin div_req.dividend = pos_q[2]; div_req.sel = DIV_BY_PCT; end
        3'd1: begin div_req.dividend = pos_q[1]; div_req.sel = DIV_BY_PCT; end
        default: begin div_req.dividend = rem_q; div_req.sel = DIV_BY_SIXTY; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q <= THR_RESET;
      out_vld_q <= 1'b0;
      k_q <= 3'd0;
      cnt_q <= 8'd0;
      for (int i = 0; i < 3; i++) begin
        sm_q[i] <= '0;
        ca_q[i] <= '0;
        e1_q[i] <= '0;
        e2_q[i] <= '0;
        pos_q[i] <= '0;
        step_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (state_q == ST_OUT && out_free) out_vld_q <= 1'b1;
      else if (pixel_o.ready) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_SMP: begin
          k_q <= 3'd0;
          for (int i = 0; i < 3; i++) begin
            sm_q[i] <= sm_new[i];
            if (changed) begin
              ca_q[i] <= sm_new[i];
              if (cmd_q.sel) e2_q[i] <= sm_new[i];
              else e1_q[i] <= sm_new[i];
            end
          end
        end
        ST_STEPW: if (div_rsp.done) begin
          step_q[k_q[1:0]] <= neg_q ? -$signed({1'b0, div_rsp.quot})
                                    : $signed({1'b0, div_rsp.quot});
          if (k_q == 3'd2) begin
            for (int i = 0; i < 3; i++) pos_q[i] <= {e1_q[i], 8'b0};
            cnt_q <= 8'd0;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_PIX: k_q <= 3'd0;
        ST_PDIVW: if (div_rsp.done) k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
        ST_MULW: k_q <= k_q + 3'd1;
        ST_OUT: if (out_free) begin
          if (cnt_q >= LAST_IDX) begin
            for (int i = 0; i < 3; i++) pos_q[i] <= {e1_q[i], 8'b0};
            cnt_q <= 8'd0;
          end else begin
            pos_q[0] <= h_next;
            pos_q[1] <= PW'(31'($signed({2'b00, pos_q[1]})) + 31'(step_q[1]));
            pos_q[2] <= PW'(31'($signed({2'b00, pos_q[2]})) + 31'(step_q[2]));
            cnt_q <= cnt_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_vld_i) cmd_q <= cmd_i;
    if (state_q == ST_STEP) neg_q <= (d_ep < 0);
    if (state_q == ST_PIX) begin
      sector_q <= sector;
      rem_q <= pos_q[0] - sec_base;
    end
    if (state_q == ST_PDIVW && div_rsp.done) begin
      unique case (k_q)
        3'd0: vf_q <= div_rsp.quot[CW-1:0];
        3'd1: sf_q <= div_rsp.quot[CW-1:0];
        default: f_q <= div_rsp.quot[CW-1:0];
      endcase
    end
    if (state_q == ST_MUL) prod_q <= mul_a * mul_b;
    if (state_q == ST_MULW) begin
      unique case (k_q)
        3'd0: p_q <= prod_q[40:20];
        3'd1: fs_q <= prod_q[40:20];
        3'd2: fs2_q <= prod_q[40:20];
        3'd3: q_q <= prod_q[40:20];
        default: t_q <= prod_q[40:20];
      endcase
    end
    if (state_q == ST_OUT && out_free) begin
      grb_q <= {to_byte(g_x), to_byte(r_x), to_byte(b_x)};
      idx_q <= cnt_q;
      last_q <= (cnt_q >= LAST_IDX);
    end
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_IDX) else $error("pixel counter past frame end");
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[0] < HUE_FULL) else $error("hue position out of range");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_OUT)) else $error("stray result");
`endif

endmodule

// ===== hdl/hsv_gradient_pixel_generator.sv =====
// Top level of the HSV gradient pixel generator.
//
//   channel    dir  handshake          payload
//   sample_i   in   valid/ready        func, hue_raw, sat_raw, val_raw, select_second
//   pixel_o    out  valid/ready        grb_word, pixel_index, last_pixel
//   cfg        in   cfg_we_i (no wait) cfg_wdata_i = change_threshold
//
// Steps: the back end handles a sample in ST_SMP and three step quotients
//   (ST_STEP, ST_STEPW), and a pixel in ST_PIX, three quotients (ST_PDIV,
//   ST_PDIVW), five products (ST_MUL, ST_MULW) and ST_OUT. A transfer passes
//   the front register and the queue before it reaches the back end.
// The front stage and the two-entry queue keep taking transfers, until both are full,
//   while the back end works or a result waits in the output register.
// Reset: asynchronous, active low; the smoothing, endpoint, position and step state
//   and the frame counter clear to zero, the threshold to 5.
// Stalls: the output register holds a result until the sink takes it.
module hsv_gradient_pixel_generator #(
  parameter int PIXEL_COUNT = 150
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  hgp_in_if.sink     sample_i,
  hgp_out_if.source  pixel_o
);
  import hgp_pkg::*;

  // front -> queue
  cmd_t f_cmd;
  logic f_vld, f_rdy;
  // queue -> back
  cmd_t b_cmd;
  logic b_vld, b_rdy;

  hgp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (sample_i),
    .cmd_o     (f_cmd),
    .cmd_vld_o (f_vld),
    .cmd_rdy_i (f_rdy)
  );

  hgp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (f_cmd),
    .vld_i  (f_vld),
    .rdy_o  (f_rdy),
    .cmd_o  (b_cmd),
    .vld_o  (b_vld),
    .rdy_i  (b_rdy)
  );

  // back end owns all color state, the threshold and the output register
  hgp_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (b_cmd),
    .cmd_vld_i   (b_vld),
    .cmd_rdy_o   (b_rdy),
    .pixel_o     (pixel_o)
  );

endmodule
